[hw/rtl/expression_token_scanner_defines.svh]
// Assertion helpers shared by the scanner modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef EXPRESSION_TOKEN_SCANNER_DEFINES_SVH
`define EXPRESSION_TOKEN_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
`define ETS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ETS_ASSERT(lbl, prop, msg)
`define ETS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/ets_pkg.sv]
`default_nettype none

package ets_pkg;

  localparam int unsigned TEXT_LEN = 65536;
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_SIGN  = 4'd1,
    PH_HOLD  = 4'd2,
    PH_NAME  = 4'd3,
    PH_MANT  = 4'd4,
    PH_EMARK = 4'd5,
    PH_EDIG  = 4'd6
  } phase_e;

  // Token kinds.
  localparam logic [4:0] KIND_NONE     = 5'd0;
  localparam logic [4:0] KIND_NAME     = 5'd0;
  localparam logic [4:0] KIND_NUMBER   = 5'd1;
  localparam logic [4:0] KIND_END      = 5'd2;
  localparam logic [4:0] KIND_PLUS     = 5'd3;
  localparam logic [4:0] KIND_MINUS    = 5'd4;
  localparam logic [4:0] KIND_STAR     = 5'd5;
  localparam logic [4:0] KIND_SLASH    = 5'd6;
  localparam logic [4:0] KIND_ASSIGN   = 5'd7;
  localparam logic [4:0] KIND_LPAREN   = 5'd8;
  localparam logic [4:0] KIND_RPAREN   = 5'd9;
  localparam logic [4:0] KIND_COMMA    = 5'd10;
  localparam logic [4:0] KIND_NOT      = 5'd11;
  localparam logic [4:0] KIND_LT       = 5'd12;
  localparam logic [4:0] KIND_GT       = 5'd13;
  localparam logic [4:0] KIND_LE       = 5'd14;
  localparam logic [4:0] KIND_GE       = 5'd15;
  localparam logic [4:0] KIND_EQ       = 5'd16;
  localparam logic [4:0] KIND_NE       = 5'd17;
  localparam logic [4:0] KIND_AND      = 5'd18;
  localparam logic [4:0] KIND_OR       = 5'd19;
  localparam logic [4:0] KIND_PLUS_EQ  = 5'd20;
  localparam logic [4:0] KIND_MINUS_EQ = 5'd21;
  localparam logic [4:0] KIND_STAR_EQ  = 5'd22;
  localparam logic [4:0] KIND_SLASH_EQ = 5'd23;
  localparam logic [4:0] KIND_ERROR    = 5'd24;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_CONTROL   = 2'd1;
  localparam logic [1:0] ERR_OTHER     = 2'd2;
  localparam logic [1:0] ERR_END_TWICE = 2'd3;

  // Characters.
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_E    = 8'h65;
  localparam logic [7:0] CH_UPPER_E    = 8'h45;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic [1:0]  err;
    logic        last;
  } result_t;

  // Results produced by one accepted byte: a finished token first, then a
  // token that the byte itself starts and completes.
  typedef struct packed {
    logic    valid_a;
    result_t res_a;
    logic    valid_b;
    result_t res_b;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [4:0] single_code(logic [7:0] c);
    logic [4:0] k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_EQUAL:  k = KIND_ASSIGN;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_COMMA:  k = KIND_COMMA;
      CH_BANG:   k = KIND_NOT;
      CH_LT:     k = KIND_LT;
      CH_GT:     k = KIND_GT;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pair_code(logic [7:0] c);
    logic [4:0] k;
    case (c)
      CH_LT:    k = KIND_LE;
      CH_GT:    k = KIND_GE;
      CH_EQUAL: k = KIND_EQ;
      CH_BANG:  k = KIND_NE;
      CH_PLUS:  k = KIND_PLUS_EQ;
      CH_MINUS: k = KIND_MINUS_EQ;
      CH_STAR:  k = KIND_STAR_EQ;
      CH_SLASH: k = KIND_SLASH_EQ;
      default:  k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ets_core.sv]
`default_nettype none
`include "expression_token_scanner_defines.svh"

module ets_core #(
  parameter int unsigned TextLen = ets_pkg::TEXT_LEN
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    char_i,
  input  wire logic          sign_op_i,
  output ets_pkg::push_t     push_o
);

  localparam int unsigned PosW = $clog2(TextLen);

  ets_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     start_q, start_d;
  logic [7:0]      run_q, run_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            end_seen_q, end_seen_d;

  logic [PosW+15:0] pos_ext;
  logic [15:0]      pos16;
  logic             absorbed;
  logic             va, vb;
  ets_pkg::result_t res_a, res_b;
  logic             dig;
  logic [7:0]       run_inc;

  assign pos_ext = {16'b0, pos_q};
  assign pos16   = pos_ext[15:0];
  assign dig     = ets_pkg::is_digit(char_i);
  assign run_inc = (run_q == 8'd255) ? run_q : run_q + 8'd1;

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    start_d    = start_q;
    run_d      = run_q;
    end_seen_d = end_seen_q;
    absorbed   = 1'b0;
    va         = 1'b0;
    vb         = 1'b0;
    res_a      = '{kind: ets_pkg::KIND_NAME, start: start_q, length: run_q,
                   err: ets_pkg::ERR_NONE, last: 1'b0};
    res_b      = '{kind: ets_pkg::KIND_NAME, start: pos16, length: 8'd1,
                   err: ets_pkg::ERR_NONE, last: 1'b1};

    // Continue the token in progress, if any.
    case (phase_q)
      ets_pkg::PH_NAME: begin
        if (ets_pkg::is_alpha(char_i) || dig || char_i == ets_pkg::CH_UNDERSCORE) begin
          run_d    = run_inc;
          absorbed = 1'b1;
        end else begin
          va = 1'b1;
        end
      end
      ets_pkg::PH_MANT: begin
        if (dig || char_i == ets_pkg::CH_DOT) begin
          run_d    = run_inc;
          absorbed = 1'b1;
        end else if (char_i == ets_pkg::CH_LOWER_E || char_i == ets_pkg::CH_UPPER_E) begin
          run_d    = run_inc;
          phase_d  = ets_pkg::PH_EMARK;
          absorbed = 1'b1;
        end else begin
          va         = 1'b1;
          res_a.kind = ets_pkg::KIND_NUMBER;
        end
      end
      ets_pkg::PH_EMARK: begin
        if (dig || char_i == ets_pkg::CH_PLUS || char_i == ets_pkg::CH_MINUS) begin
          run_d    = run_inc;
          phase_d  = ets_pkg::PH_EDIG;
          absorbed = 1'b1;
        end else begin
          va         = 1'b1;
          res_a.kind = ets_pkg::KIND_NUMBER;
        end
      end
      ets_pkg::PH_EDIG: begin
        if (dig) begin
          run_d    = run_inc;
          absorbed = 1'b1;
        end else begin
          va         = 1'b1;
          res_a.kind = ets_pkg::KIND_NUMBER;
        end
      end
      ets_pkg::PH_SIGN, ets_pkg::PH_HOLD: begin
        if (((phase_q == ets_pkg::PH_SIGN) && (dig || char_i == ets_pkg::CH_DOT)) ||
            (held_q == ets_pkg::CH_DOT && dig)) begin
          run_d    = 8'd2;
          phase_d  = ets_pkg::PH_MANT;
          absorbed = 1'b1;
        end else if (char_i == ets_pkg::CH_EQUAL &&
                     ets_pkg::pair_code(held_q) != ets_pkg::KIND_NONE) begin
          va           = 1'b1;
          res_a.kind   = ets_pkg::pair_code(held_q);
          res_a.length = 8'd2;
          absorbed     = 1'b1;
        end else if (held_q == ets_pkg::CH_AMP && char_i == ets_pkg::CH_AMP) begin
          va           = 1'b1;
          res_a.kind   = ets_pkg::KIND_AND;
          res_a.length = 8'd2;
          absorbed     = 1'b1;
        end else if (held_q == ets_pkg::CH_BAR && char_i == ets_pkg::CH_BAR) begin
          va           = 1'b1;
          res_a.kind   = ets_pkg::KIND_OR;
          res_a.length = 8'd2;
          absorbed     = 1'b1;
        end else if (ets_pkg::single_code(held_q) != ets_pkg::KIND_NONE) begin
          va           = 1'b1;
          res_a.kind   = ets_pkg::single_code(held_q);
          res_a.length = 8'd1;
        end else begin
          va           = 1'b1;
          res_a.kind   = ets_pkg::KIND_ERROR;
          res_a.length = 8'd1;
          res_a.err    = ets_pkg::ERR_OTHER;
        end
      end
      default: begin
        phase_d = ets_pkg::PH_IDLE;
      end
    endcase

    if (va) begin
      phase_d = ets_pkg::PH_IDLE;
      if (res_a.kind != ets_pkg::KIND_ERROR) begin
        end_seen_d = 1'b0;
      end
    end

    // A byte not taken by the token in progress starts something new.
    if (!absorbed) begin
      if (char_i == ets_pkg::CH_NUL) begin
        vb           = 1'b1;
        res_b.length = 8'd0;
        if (end_seen_d) begin
          res_b.kind = ets_pkg::KIND_ERROR;
          res_b.err  = ets_pkg::ERR_END_TWICE;
        end else begin
          res_b.kind = ets_pkg::KIND_END;
          end_seen_d = 1'b1;
        end
      end else if (!ets_pkg::is_space(char_i)) begin
        start_d = pos16;
        run_d   = 8'd1;
        held_d  = char_i;
        if (dig) begin
          phase_d = ets_pkg::PH_MANT;
        end else if (ets_pkg::is_alpha(char_i)) begin
          phase_d = ets_pkg::PH_NAME;
        end else if (char_i == ets_pkg::CH_LPAREN || char_i == ets_pkg::CH_RPAREN ||
                     char_i == ets_pkg::CH_COMMA) begin
          vb         = 1'b1;
          res_b.kind = ets_pkg::single_code(char_i);
          end_seen_d = 1'b0;
        end else if ((char_i == ets_pkg::CH_PLUS || char_i == ets_pkg::CH_MINUS) &&
                     !sign_op_i) begin
          phase_d = ets_pkg::PH_SIGN;
        end else if (char_i == ets_pkg::CH_PLUS || char_i == ets_pkg::CH_MINUS ||
                     char_i == ets_pkg::CH_DOT || char_i == ets_pkg::CH_AMP ||
                     char_i == ets_pkg::CH_BAR ||
                     ets_pkg::pair_code(char_i) != ets_pkg::KIND_NONE) begin
          phase_d = ets_pkg::PH_HOLD;
        end else begin
          vb         = 1'b1;
          res_b.kind = ets_pkg::KIND_ERROR;
          res_b.err  = (char_i < ets_pkg::CH_SPACE) ? ets_pkg::ERR_CONTROL
                                                    : ets_pkg::ERR_OTHER;
        end
      end
    end

    res_a.last = !vb;

    if (char_i == ets_pkg::CH_NUL) begin
      pos_d = '0;
    end else if (pos_q == PosW'(TextLen - 1)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ets_pkg::PH_IDLE;
      held_q     <= '0;
      start_q    <= '0;
      run_q      <= '0;
      pos_q      <= '0;
      end_seen_q <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      start_q    <= start_d;
      run_q      <= run_d;
      pos_q      <= pos_d;
      end_seen_q <= end_seen_d;
    end
  end

  assign push_o = '{valid_a: accept_i && va, res_a: res_a,
                    valid_b: accept_i && vb, res_b: res_b};

  `ETS_ASSERT(a_sign_char, (phase_q == ets_pkg::PH_SIGN) |-> (held_q == ets_pkg::CH_PLUS || held_q == ets_pkg::CH_MINUS), "sign phase without a sign character")
  `ETS_ASSERT(a_hold_char, (phase_q == ets_pkg::PH_HOLD) |-> (ets_pkg::pair_code(held_q) != ets_pkg::KIND_NONE || held_q == ets_pkg::CH_DOT || held_q == ets_pkg::CH_AMP || held_q == ets_pkg::CH_BAR), "hold phase with a bad character")
  `ETS_ASSERT_NEXT(a_end_marks, push_o.valid_b && push_o.res_b.kind == ets_pkg::KIND_END, end_seen_q, "end token did not set end_seen")

endmodule

`default_nettype wire

[hw/rtl/ets_out_fifo.sv]
`default_nettype none
`include "expression_token_scanner_defines.svh"

module ets_out_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ets_pkg::push_t    push_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              pop_ready_i,
  output ets_pkg::result_t       data_o
);

  localparam int unsigned PtrW = $clog2(ets_pkg::OUT_DEPTH);
  localparam int unsigned CntW = $clog2(ets_pkg::OUT_DEPTH + 1);

  ets_pkg::result_t mem_q [ets_pkg::OUT_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       n_push;
  logic             pop;
  ets_pkg::result_t first;
  logic [PtrW-1:0]  wr_next;

  assign n_push  = {1'b0, push_i.valid_a} + {1'b0, push_i.valid_b};
  assign first   = push_i.valid_a ? push_i.res_a : push_i.res_b;
  assign wr_next = wr_ptr_q + PtrW'(1);
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign ready_o = (cnt_q <= CntW'(ets_pkg::OUT_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= first;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_next] <= push_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `ETS_ASSERT(a_cnt_bound, cnt_q <= CntW'(ets_pkg::OUT_DEPTH), "result queue count out of range")
  `ETS_ASSERT(a_push_room, (n_push != 2'd0) |-> (cnt_q <= CntW'(ets_pkg::OUT_DEPTH - 2)), "push without room")
  `ETS_ASSERT_NEXT(a_dual_push, n_push == 2'd2 && !pop, cnt_q == $past(cnt_q) + CntW'(2), "double push count slip")

endmodule

`default_nettype wire

[hw/rtl/expression_token_scanner.sv]
`default_nettype none

// Streaming lexer for arithmetic expressions. One text byte is taken per
// request on the slave side (byte 0 ends the text and restarts the offset
// count); tokens come out on the master side, most once the byte after them
// arrives (parentheses, commas, ends and bad bytes with the byte itself), so
// one byte gives zero, one or two tokens. The scanner state advances in the
// cycle a byte is accepted and its tokens are visible on the master side from
// the next cycle. A new byte is accepted every cycle while the four-entry result
// queue has two free slots, so the sustained rate is one byte per cycle while
// bytes average at most one token each and the master side takes every token.
module expression_token_scanner #(
  parameter int unsigned TextLen = ets_pkg::TEXT_LEN
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_byte
  input  wire logic [0:0]  s_axis_tuser,  // [0] sign_as_operator
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [4:0] token_kind, [20:5] token_start,
                                          // [28:21] token_length, [30:29] error_code
  output logic             m_axis_tlast   // last_of_run
);

  ets_pkg::push_t   push;
  ets_pkg::result_t head;
  logic             accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  ets_core #(
    .TextLen (TextLen)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .char_i    (s_axis_tdata),
    .sign_op_i (s_axis_tuser[0]),
    .push_o    (push)
  );

  ets_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (head)
  );

  assign m_axis_tdata = {1'b0, head.err, head.length, head.start, head.kind};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

[bench/token_stream_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the scanner, predicts the tokens of every accepted
// byte and compares them in order with what comes out on the master side.
module token_stream_checker
  import ets_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic [0:0]  s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [31:0] m_data_i,
  input  logic        m_last_i,
  output int          fail_count_o,
  output int          pending_o
);

  phase_e      phase;
  logic [7:0]  lead_char;
  logic [15:0] tok_start;
  logic [7:0]  tok_len;
  logic [15:0] text_pos;
  logic        after_end;
  result_t     expected_tokens[$];

  function automatic logic digit_char(logic [7:0] c);
    return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
  endfunction

  function automatic logic letter_char(logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [4:0] lone_kind(logic [7:0] c);
    case (c)
      CH_PLUS:   return KIND_PLUS;
      CH_MINUS:  return KIND_MINUS;
      CH_STAR:   return KIND_STAR;
      CH_SLASH:  return KIND_SLASH;
      CH_EQUAL:  return KIND_ASSIGN;
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_COMMA:  return KIND_COMMA;
      CH_BANG:   return KIND_NOT;
      CH_LT:     return KIND_LT;
      CH_GT:     return KIND_GT;
      default:   return KIND_NONE;
    endcase
  endfunction

  function automatic logic [4:0] paired_kind(logic [7:0] c);
    case (c)
      CH_LT:    return KIND_LE;
      CH_GT:    return KIND_GE;
      CH_EQUAL: return KIND_EQ;
      CH_BANG:  return KIND_NE;
      CH_PLUS:  return KIND_PLUS_EQ;
      CH_MINUS: return KIND_MINUS_EQ;
      CH_STAR:  return KIND_STAR_EQ;
      CH_SLASH: return KIND_SLASH_EQ;
      default:  return KIND_NONE;
    endcase
  endfunction

  task automatic emit(input logic [4:0] kind, input logic [15:0] start,
                      input logic [7:0] len, input logic [1:0] err);
    expected_tokens.push_back('{kind: kind, start: start, length: len, err: err,
                                last: 1'b0});
    // Only real tokens re-arm the end marker; errors leave it alone.
    if (kind != KIND_ERROR && kind != KIND_END) after_end = 1'b0;
  endtask

  task automatic grow_token();
    if (tok_len != 8'hFF) tok_len++;
  endtask

  task automatic finish_token(input logic [4:0] kind, input logic [7:0] len);
    emit(kind, tok_start, len, ERR_NONE);
    phase = PH_IDLE;
  endtask

  task automatic scan_char(input logic [7:0] c, input logic sign_op);
    logic        taken;
    logic [15:0] pos;
    int          before_count;
    taken = 1'b0;
    pos = text_pos;
    before_count = expected_tokens.size();

    // First let the token in progress absorb or close on this byte.
    case (phase)
      PH_NAME: begin
        if (letter_char(c) || digit_char(c) || c == CH_UNDERSCORE) begin
          grow_token();
          taken = 1'b1;
        end else begin
          finish_token(KIND_NAME, tok_len);
        end
      end
      PH_MANT: begin
        if (digit_char(c) || c == CH_DOT) begin
          grow_token();
          taken = 1'b1;
        end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
          grow_token();
          phase = PH_EMARK;
          taken = 1'b1;
        end else begin
          finish_token(KIND_NUMBER, tok_len);
        end
      end
      PH_EMARK: begin
        if (c == CH_PLUS || c == CH_MINUS || digit_char(c)) begin
          grow_token();
          phase = PH_EDIG;
          taken = 1'b1;
        end else begin
          finish_token(KIND_NUMBER, tok_len);
        end
      end
      PH_EDIG: begin
        if (digit_char(c)) begin
          grow_token();
          taken = 1'b1;
        end else begin
          finish_token(KIND_NUMBER, tok_len);
        end
      end
      PH_SIGN, PH_HOLD: begin
        if ((phase == PH_SIGN && (digit_char(c) || c == CH_DOT)) ||
            (lead_char == CH_DOT && digit_char(c))) begin
          tok_len = 8'd2;
          phase = PH_MANT;
          taken = 1'b1;
        end else if (c == CH_EQUAL && paired_kind(lead_char) != KIND_NONE) begin
          finish_token(paired_kind(lead_char), 8'd2);
          taken = 1'b1;
        end else if (lead_char == CH_AMP && c == CH_AMP) begin
          finish_token(KIND_AND, 8'd2);
          taken = 1'b1;
        end else if (lead_char == CH_BAR && c == CH_BAR) begin
          finish_token(KIND_OR, 8'd2);
          taken = 1'b1;
        end else if (lone_kind(lead_char) != KIND_NONE) begin
          finish_token(lone_kind(lead_char), 8'd1);
        end else begin
          emit(KIND_ERROR, tok_start, 8'd1, ERR_OTHER);
          phase = PH_IDLE;
        end
      end
      default: phase = PH_IDLE;
    endcase

    // A byte not taken by the old token starts a new one, ends the text, or is skipped.
    if (!taken) begin
      if (c == CH_NUL) begin
        if (after_end) begin
          emit(KIND_ERROR, pos, 8'd0, ERR_END_TWICE);
        end else begin
          emit(KIND_END, pos, 8'd0, ERR_NONE);
          after_end = 1'b1;
        end
      end else if (!blank_char(c)) begin
        tok_start = pos;
        tok_len = 8'd1;
        lead_char = c;
        if (digit_char(c)) begin
          phase = PH_MANT;
        end else if (letter_char(c)) begin
          phase = PH_NAME;
        end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA) begin
          emit(lone_kind(c), pos, 8'd1, ERR_NONE);
        end else if ((c == CH_PLUS || c == CH_MINUS) && !sign_op) begin
          phase = PH_SIGN;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_DOT || c == CH_AMP ||
                     c == CH_BAR || paired_kind(c) != KIND_NONE) begin
          phase = PH_HOLD;
        end else begin
          emit(KIND_ERROR, pos, 8'd1, (c < CH_SPACE) ? ERR_CONTROL : ERR_OTHER);
        end
      end
    end

    if (expected_tokens.size() > before_count)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    text_pos = (c == CH_NUL) ? 16'd0 : pos + 16'd1;
  endtask

  task automatic check_field(input string what, input int want, input int got,
                             inout logic bad);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    logic    bad;
    if (!rst_ni) begin
      phase = PH_IDLE;
      lead_char = 8'd0;
      tok_start = 16'd0;
      tok_len = 8'd0;
      text_pos = 16'd0;
      after_end = 1'b0;
      expected_tokens.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // Tokens of a byte accepted in this cycle cannot be out yet.
      if (m_valid_i && m_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: token with none expected, tdata %h tlast %b",
                   $time, m_data_i, m_last_i);
          fail_count_o++;
        end else begin
          want = expected_tokens.pop_front();
          bad = 1'b0;
          check_field("token_kind", want.kind, m_data_i[4:0], bad);
          check_field("token_start", want.start, m_data_i[20:5], bad);
          check_field("token_length", want.length, m_data_i[28:21], bad);
          check_field("error_code", want.err, m_data_i[30:29], bad);
          check_field("last_of_run", want.last, m_last_i, bad);
          if (bad) fail_count_o++;
        end
      end
      if (s_valid_i && s_ready_i) scan_char(s_data_i, s_user_i[0]);
      pending_o = expected_tokens.size();
    end
  end

endmodule

[bench/expression_token_scanner_tb.sv]
`timescale 1ns / 1ps

module expression_token_scanner_tb;
  import ets_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_byte
  logic [0:0]  s_axis_tuser;   // [0] sign_as_operator
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [4:0] kind, [20:5] start, [28:21] length, [30:29] error
  logic        m_axis_tlast;   // last_of_run

  int   failures;
  int   expected_left;
  int   hold_requests = 0;
  int   burst_left = 0;
  logic steady = 1'b0;

  string op_text[21] = '{"+", "-", "*", "/", "=", "(", ")", ",", "!", "<", ">",
                         "<=", ">=", "==", "!=", "&&", "||", "+=", "-=", "*=", "/="};

  expression_token_scanner dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  token_stream_checker u_token_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .fail_count_o (failures),
    .pending_o    (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  // Token side: a rotating stall pattern, plus a long hold-off on request.
  initial begin
    int cycle;
    int holds_done;
    cycle = 0;
    holds_done = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (holds_done != hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk);
        holds_done++;
      end else begin
        case ((cycle / 97) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          default: m_axis_tready <= ((cycle % 5) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic sign_op);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= sign_op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string t, input logic sign_op);
    for (int i = 0; i < t.len(); i++) send_byte(t[i], sign_op);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (expected_left != 0);
  endtask

  function automatic logic [7:0] random_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] random_letter();
    return $urandom_range(0, 1) ? CH_LOWER_A + 8'($urandom_range(0, 25))
                                : CH_UPPER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_DIGIT_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_sign();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  // Mostly well-formed tokens with random content, some blanks, ends and noise.
  task automatic send_token(inout int counted);
    logic [7:0] spelled[$];
    string      op;
    int         pick;
    int         n;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      spelled.push_back(random_letter());
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       spelled.push_back(random_digit());
          1:       spelled.push_back(CH_UNDERSCORE);
          default: spelled.push_back(random_letter());
        endcase
      end
    end else if (pick < 44) begin
      if ($urandom_range(0, 2) == 0) spelled.push_back(random_sign());
      n = $urandom_range(1, 5);
      repeat (n) spelled.push_back($urandom_range(0, 4) == 0 ? CH_DOT : random_digit());
      if ($urandom_range(0, 2) == 0) begin
        spelled.push_back($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
        if ($urandom_range(0, 1)) spelled.push_back(random_sign());
        n = $urandom_range(0, 3);
        repeat (n) spelled.push_back(random_digit());
      end
    end else if (pick < 80) begin
      op = op_text[$urandom_range(0, 20)];
      for (int i = 0; i < op.len(); i++) spelled.push_back(op[i]);
    end else if (pick < 86) begin
      spelled.push_back(random_blank());
    end else if (pick < 91) begin
      spelled.push_back(CH_NUL);
    end else begin
      spelled.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) spelled.push_back(random_blank());
    foreach (spelled[i]) begin
      send_byte(spelled[i], $urandom_range(0, 1));
      if (!(spelled[i] == CH_SPACE || (spelled[i] >= CH_TAB && spelled[i] <= CH_CR)))
        counted++;
    end
  endtask

  initial begin
    int real_items;
    int next_break;
    rst_n = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tuser = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Short directed text: signed numbers with exponents, paired operators,
    // lone dot, ampersand and bar, control and high bytes, end after end.
    send_text("a_1<=-.5e+7", 1'b0);
    send_text("&&||.&|", 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("+x 2E", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_NUL, 1'b1);
    drain();

    // Names and numbers longer than the length field can hold.
    send_byte(CH_LOWER_A, 1'b0);
    repeat (257) send_byte(CH_LOWER_Z, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    repeat (258) send_byte(random_digit(), 1'b0);
    send_byte(CH_NUL, 1'b0);
    drain();

    // Long hold-off on the token side while bytes keep coming.
    steady = 1'b1;
    hold_requests++;
    repeat (30) send_byte(CH_LPAREN, 1'b0);
    steady = 1'b0;
    drain();

    real_items = 0;
    next_break = 80;
    while (real_items < 200) begin
      send_token(real_items);
      if (real_items >= next_break) begin
        steady = !steady;
        drain();
        next_break += 80;
      end
    end
    send_byte(CH_NUL, 1'b0);
    drain();
    repeat (16) @(negedge clk);

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ets_pkg.sv
hw/rtl/ets_core.sv
hw/rtl/ets_out_fifo.sv
hw/rtl/expression_token_scanner.sv
bench/token_stream_checker.sv
bench/expression_token_scanner_tb.sv
